// ----- rtl/core/lamf_pkg.sv -----
// Shared definitions for the local alignment matrix fill block.
// Holds the register indexes, direction codes, score widths and the controller command type.
// No dependencies.
package lamf_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_MATCH    = 2'd0;
  localparam logic [1:0] REG_MISMATCH = 2'd1;
  localparam logic [1:0] REG_GAP      = 2'd2;

  // Traceback direction codes.
  localparam logic [1:0] DIR_DIAG  = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_START = 2'd3;

  // Score widths: stored scores are 10 bits; candidates need 12 bits signed.
  localparam int SCORE_W = 10;
  localparam int CAND_W  = 12;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 10'd1023;

  // Reset values of the scoring registers.
  localparam logic [3:0] MATCH_RST    = 4'd2;
  localparam logic [4:0] MISMATCH_RST = 5'b11101;
  localparam logic [5:0] GAP_RST      = 6'b111010;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ref_we;     // write the input symbol into the reference store
    logic row_start;  // latch the query symbol and clear the running scores
    logic rd_en;      // read one column of the reference and the stored row
    logic up_valid;   // the stored row entry being read holds a real score
    logic last;       // the column being read is the last of the row
    logic cell_en;    // compute the pending cell and load the output register
  } lamf_cmd_t;

endpackage

// ----- rtl/core/lamf_ctrl.sv -----
// Controller for the local alignment matrix fill block.
// Sequences reference loads and row passes and tracks the reference length and the row fill count.
// Depends on lamf_pkg.
module lamf_ctrl
  import lamf_pkg::*;
#(
  parameter int MAX_REF_LEN = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_mode,
  input  logic                                   in_restart,
  input  logic                                   slot_free,
  output lamf_cmd_t                              cmd,
  output logic [((MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1)-1:0] ref_addr,
  output logic [((MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1)-1:0] rd_addr,
  output logic [$clog2(MAX_REF_LEN + 1)-1:0]     rd_col
);

  localparam int ADDR_W = (MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1;
  localparam int CNT_W  = $clog2(MAX_REF_LEN + 1);
  localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(MAX_REF_LEN);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ROW  = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] filled_r, filled_nxt;
  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_last_r, s1_last_nxt;

  logic             accept;
  logic             issue_ok;
  logic             cell_en;
  logic [CNT_W-1:0] iss_inc;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign iss_inc  = iss_r + 1'b1;
  assign cell_en  = (state_r == ST_ROW) && s1_valid_r && slot_free;
  assign issue_ok = (state_r == ST_ROW) && (iss_r < len_r) && (!s1_valid_r || cell_en);

  // Read addressing for the row pass.
  assign rd_addr = iss_r[ADDR_W-1:0];
  assign rd_col  = iss_inc;
  assign ref_addr = in_restart ? '0 : len_r[ADDR_W-1:0];

  // Next-state and command logic.
  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    filled_nxt   = filled_r;
    iss_nxt      = iss_r;
    s1_valid_nxt = s1_valid_r;
    s1_last_nxt  = s1_last_r;
    cmd          = '0;
    cmd.rd_en    = issue_ok;
    cmd.up_valid = iss_r < filled_r;
    cmd.last     = (iss_inc == len_r);
    cmd.cell_en  = cell_en;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_restart) begin
            filled_nxt = '0;
          end
          if (!in_mode) begin
            // A load appends one symbol unless the store is full; a restart load starts anew.
            if (in_restart) begin
              cmd.ref_we = 1'b1;
              len_nxt    = CNT_W'(1);
            end else if (len_r < LEN_MAX) begin
              cmd.ref_we = 1'b1;
              len_nxt    = len_r + 1'b1;
            end
          end else if (len_r != '0) begin
            cmd.row_start = 1'b1;
            iss_nxt       = '0;
            state_nxt     = ST_ROW;
          end
        end
      end
      ST_ROW: begin
        if (issue_ok) begin
          iss_nxt      = iss_inc;
          s1_valid_nxt = 1'b1;
          s1_last_nxt  = (iss_inc == len_r);
        end else if (cell_en) begin
          s1_valid_nxt = 1'b0;
        end
        // The whole row has been written back once its last cell leaves.
        if (cell_en && s1_last_r) begin
          filled_nxt = len_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      len_r      <= '0;
      filled_r   <= '0;
      iss_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_last_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      filled_r   <= filled_nxt;
      iss_r      <= iss_nxt;
      s1_valid_r <= s1_valid_nxt;
      s1_last_r  <= s1_last_nxt;
    end
  end

endmodule

// ----- rtl/core/lamf_datapath.sv -----
// Datapath for the local alignment matrix fill block.
// Holds the scoring registers, the reference and row memories, the cell scorer and the output register.
// Depends on lamf_pkg.
module lamf_datapath
  import lamf_pkg::*;
#(
  parameter int MAX_REF_LEN = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_index,
  input  logic [5:0]                             cfg_data,
  input  logic [7:0]                             in_symbol,
  input  lamf_cmd_t                              cmd,
  input  logic [((MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1)-1:0] ref_addr,
  input  logic [((MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1)-1:0] rd_addr,
  input  logic [$clog2(MAX_REF_LEN + 1)-1:0]     rd_col,
  output logic                                   slot_free,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [SCORE_W-1:0]                     out_score,
  output logic [1:0]                             out_direction,
  output logic [6:0]                             out_column,
  output logic                                   out_row_end
);

  localparam int ADDR_W = (MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1;
  localparam int CNT_W  = $clog2(MAX_REF_LEN + 1);

  logic [3:0] match_r;
  logic [4:0] mismatch_r;
  logic [5:0] gap_r;

  logic [7:0]         ref_mem [MAX_REF_LEN];
  logic [SCORE_W-1:0] row_mem [MAX_REF_LEN];

  logic [7:0]         qsym_r;
  logic [7:0]         ref_rd_r;
  logic [SCORE_W-1:0] row_rd_r;
  logic               up_valid_r;
  logic [ADDR_W-1:0]  cell_addr_r;
  logic [CNT_W-1:0]   cell_col_r;
  logic               cell_last_r;
  logic [SCORE_W-1:0] diag_r;
  logic [SCORE_W-1:0] left_r;

  logic               out_valid_r;
  logic [SCORE_W-1:0] out_score_r;
  logic [1:0]         out_dir_r;
  logic [6:0]         out_col_r;
  logic               out_end_r;

  logic [SCORE_W-1:0]       up;
  logic signed [CAND_W-1:0] sub;
  logic signed [CAND_W-1:0] gap;
  logic signed [CAND_W-1:0] c_diag, c_up, c_left;
  logic signed [CAND_W-1:0] best;
  logic [1:0]               dir;
  logic [SCORE_W-1:0]       best_sat;

  // Scoring registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r    <= MATCH_RST;
      mismatch_r <= MISMATCH_RST;
      gap_r      <= GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATCH:    match_r    <= cfg_data[3:0];
        REG_MISMATCH: mismatch_r <= cfg_data[4:0];
        REG_GAP:      gap_r      <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Reference store: written on loads, read one column a cycle during a row while the output register can take cells.
  always_ff @(posedge clk) begin
    if (cmd.ref_we) begin
      ref_mem[ref_addr] <= in_symbol;
    end
    if (cmd.rd_en) begin
      ref_rd_r <= ref_mem[rd_addr];
    end
  end

  // Previous row scores: read ahead of the cell, written back as it completes.
  always_ff @(posedge clk) begin
    if (cmd.cell_en) begin
      row_mem[cell_addr_r] <= best_sat;
    end
    if (cmd.rd_en) begin
      row_rd_r <= row_mem[rd_addr];
    end
  end

  // Side information that travels with each read.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      up_valid_r  <= cmd.up_valid;
      cell_addr_r <= rd_addr;
      cell_col_r  <= rd_col;
      cell_last_r <= cmd.last;
    end
    if (cmd.row_start) begin
      qsym_r <= in_symbol;
    end
  end

  // Cell scorer: the best of diagonal, up, left and zero, earliest wins ties.
  assign up  = up_valid_r ? row_rd_r : '0;
  assign sub = (ref_rd_r == qsym_r) ? $signed({{(CAND_W-4){1'b0}}, match_r})
                                    : $signed({{(CAND_W-5){mismatch_r[4]}}, mismatch_r});
  assign gap = $signed({{(CAND_W-6){gap_r[5]}}, gap_r});
  assign c_diag = $signed({{(CAND_W-SCORE_W){1'b0}}, diag_r}) + sub;
  assign c_up   = $signed({{(CAND_W-SCORE_W){1'b0}}, up}) + gap;
  assign c_left = $signed({{(CAND_W-SCORE_W){1'b0}}, left_r}) + gap;

  always_comb begin
    best = c_diag;
    dir  = DIR_DIAG;
    if (c_up > best) begin
      best = c_up;
      dir  = DIR_UP;
    end
    if (c_left > best) begin
      best = c_left;
      dir  = DIR_LEFT;
    end
    if (best < 0) begin
      best = '0;
      dir  = DIR_START;
    end
    if (best > $signed({{(CAND_W-SCORE_W){1'b0}}, SCORE_MAX})) begin
      best_sat = SCORE_MAX;
    end else begin
      best_sat = best[SCORE_W-1:0];
    end
  end

  // Running diagonal and left scores along the row.
  always_ff @(posedge clk) begin
    if (cmd.row_start) begin
      diag_r <= '0;
      left_r <= '0;
    end else if (cmd.cell_en) begin
      diag_r <= up;
      left_r <= best_sat;
    end
  end

  // Output register: holds a finished cell until the consumer takes it.
  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.cell_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cell_en) begin
      out_score_r <= best_sat;
      out_dir_r   <= dir;
      out_col_r   <= 7'(cell_col_r);
      out_end_r   <= cell_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_score     = out_score_r;
  assign out_direction = out_dir_r;
  assign out_column    = out_col_r;
  assign out_row_end   = out_end_r;

endmodule

// ----- rtl/core/local_align_matrix_fill_unit.sv -----
// Local alignment matrix fill unit: Smith-Waterman rows with a linear gap penalty.
// A reference load gives no result and leaves in_ready high.
// A query row of N columns reads the reference and the stored row, then scores each cell into
// the output register, one cell a cycle while out_ready keeps the output register free.
// Reset is synchronous and active low; it empties the reference and marks the stored row empty, so it reads as zero.
module local_align_matrix_fill_unit
  import lamf_pkg::*;
#(
  parameter int MAX_REF_LEN = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic               in_restart,
  input  logic [7:0]         in_symbol,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SCORE_W-1:0] out_score,
  output logic [1:0]         out_direction,
  output logic [6:0]         out_column,
  output logic               out_row_end
);

  localparam int ADDR_W = (MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1;
  localparam int CNT_W  = $clog2(MAX_REF_LEN + 1);

  lamf_cmd_t         cmd;
  logic              slot_free;
  logic [ADDR_W-1:0] ref_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  rd_col;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  lamf_ctrl #(
    .MAX_REF_LEN(MAX_REF_LEN)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_restart(in_restart),
    .slot_free (slot_free),
    .cmd       (cmd),
    .ref_addr  (ref_addr),
    .rd_addr   (rd_addr),
    .rd_col    (rd_col)
  );

  lamf_datapath #(
    .MAX_REF_LEN(MAX_REF_LEN)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_symbol    (in_symbol),
    .cmd          (cmd),
    .ref_addr     (ref_addr),
    .rd_addr      (rd_addr),
    .rd_col       (rd_col),
    .slot_free    (slot_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_score    (out_score),
    .out_direction(out_direction),
    .out_column   (out_column),
    .out_row_end  (out_row_end)
  );

endmodule
